FILE: hdl/lwp_pkg.sv
// Package for the latency window percentile unit.
// Holds field widths, reciprocal constants and the controller/datapath interface types.
// No dependencies.
package lwp_pkg;

  // Field widths
  localparam int LAT_W = 24;
  localparam int CNT_W = 11;
  localparam int COUNT_MAX = 2047;

  // ceil(n/20) = floor((n+19)/20) and ceil(n/100) = floor((n+99)/100), by reciprocal.
  // Both are exact for sums below 43690, well above any supported window.
  localparam int DIV_SHIFT = 19;
  localparam int ADD20 = 19;
  localparam int MUL20 = 26215;
  localparam int ADD100 = 99;
  localparam int MUL100 = 5243;
  localparam int MUL_W = 15;

  // Sorted-bank read address source
  typedef enum logic [1:0] {
    RSEL_SCAN = 2'd0,
    RSEL_P50  = 2'd1,
    RSEL_P95  = 2'd2,
    RSEL_P99  = 2'd3
  } rsel_t;

  // Commands from the controller
  typedef struct packed {
    logic  accept;
    logic  load;
    logic  merge;
    logic  fin;
    logic  div;
    logic  idx;
    logic  cap_med;
    logic  cap_p95;
    logic  push;
    rsel_t rsel;
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic merge_done;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/latency_window_percentiles_unit.sv
// Top level of the latency window percentile unit.
// Joins the controller and datapath; depends on lwp_pkg, lwp_ctrl and lwp_dpath.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------------------
//   in      | input     | in_valid, in_stall, in_latency_us
//   out     | output    | out_valid, out_stall, out_median_us, out_pct95_us,
//           |           | out_pct99_us, out_nonzero_count
//
// A word's result follows its accept after a load step and a merge sweep through the
// sorted bank over the n nonzero samples held before it; the sweep moves one element a
// cycle over one memory read port, then index math and three percentile reads follow.
// The next word can be taken in the cycle after the result is pushed.
// No clearing pass after reset: a fill flag masks ring slots not yet written.
// A result waits in the output register; a stalled output holds the unit at its last step.
module latency_window_percentiles_unit #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lwp_pkg::LAT_W-1:0]  in_latency_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lwp_pkg::LAT_W-1:0]  out_median_us,
  output logic [lwp_pkg::LAT_W-1:0]  out_pct95_us,
  output logic [lwp_pkg::LAT_W-1:0]  out_pct99_us,
  output logic [lwp_pkg::CNT_W-1:0]  out_nonzero_count
);

  lwp_pkg::cmd_t  cmd;
  lwp_pkg::stat_t st;

  lwp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lwp_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_latency_us     (in_latency_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_median_us     (out_median_us),
    .out_pct95_us      (out_pct95_us),
    .out_pct99_us      (out_pct99_us),
    .out_nonzero_count (out_nonzero_count)
  );

`ifndef SYNTHESIS
  // One word at a time
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in progress");

  // Never overwrite a result still waiting
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> st.out_free)
    else $error("result pushed into a full output register");

  // Index math follows the end of the merge
  a_fin_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> cmd.div)
    else $error("merge end not followed by index math");

  // Empty window reports all zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_nonzero_count == '0)) |->
    ((out_median_us == '0) && (out_pct95_us == '0) && (out_pct99_us == '0)))
    else $error("nonzero percentile with empty window");
`endif

endmodule

FILE: hdl/lwp_ctrl.sv
// Controller for the latency window percentile unit.
// Sequences load, merge sweep, index math, percentile reads and result push.
// Depends on lwp_pkg.
module lwp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lwp_pkg::stat_t st,
  output lwp_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_MERGE = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_IDX   = 9'b000010000,
    S_RD50  = 9'b000100000,
    S_RD95  = 9'b001000000,
    S_RD99  = 9'b010000000,
    S_PUSH  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Take a new word only when idle
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rsel = lwp_pkg::RSEL_SCAN;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (st.merge_done) begin
          cmd.fin = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx = 1'b1;
        state_nxt = S_RD50;
      end
      S_RD50: begin
        cmd.rsel = lwp_pkg::RSEL_P50;
        state_nxt = S_RD95;
      end
      S_RD95: begin
        cmd.rsel = lwp_pkg::RSEL_P95;
        cmd.cap_med = 1'b1;
        state_nxt = S_RD99;
      end
      S_RD99: begin
        cmd.rsel = lwp_pkg::RSEL_P99;
        cmd.cap_p95 = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.rsel = lwp_pkg::RSEL_P99;
        if (st.out_free) begin
          cmd.push = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/lwp_dpath.sv
// Datapath for the latency window percentile unit.
// Sample ring, two ping-pong sorted banks, merge sweep, index math and output register.
// Depends on lwp_pkg.
module lwp_dpath #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lwp_pkg::cmd_t              cmd,
  output lwp_pkg::stat_t             st,
  input  logic [lwp_pkg::LAT_W-1:0]  in_latency_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lwp_pkg::LAT_W-1:0]  out_median_us,
  output logic [lwp_pkg::LAT_W-1:0]  out_pct95_us,
  output logic [lwp_pkg::LAT_W-1:0]  out_pct99_us,
  output logic [lwp_pkg::CNT_W-1:0]  out_nonzero_count
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int XW = CW + 7;
  localparam int PW = XW + lwp_pkg::MUL_W;
  localparam int LW = lwp_pkg::LAT_W;

  // Storage
  logic [LW-1:0] ring_mem [WINDOW_DEPTH];
  logic [LW-1:0] bank0_mem [WINDOW_DEPTH];
  logic [LW-1:0] bank1_mem [WINDOW_DEPTH];
  logic [LW-1:0] ring_rd_r, bank0_rd_r, bank1_rd_r;

  // Control and payload registers
  logic [AW-1:0] ws_r;
  logic          full_r;
  logic [CW-1:0] n_r;
  logic          sel_r;
  logic [LW-1:0] lat_r, old_r;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          rm_r, rm_nxt, ins_r, ins_nxt;
  logic [CW-1:0] q20_r, q100_r, idx95_r, idx99_r;
  logic [LW-1:0] med_r, p95_r;
  logic          out_valid_r;
  logic [LW-1:0] med_out_r, p95_out_r, p99_out_r;
  logic [lwp_pkg::CNT_W-1:0] cnt_out_r;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [LW-1:0] wr_data, rd_data;
  logic          exhausted, need_rm, need_ins;
  logic [XW-1:0] sum20, sum100;
  logic [PW-1:0] prod20, prod100;
  logic [CW-1:0] idx50;
  logic [CW+lwp_pkg::CNT_W-1:0] n_ext;
  logic [lwp_pkg::CNT_W-1:0]    cnt_sat;

  assign rd_data = sel_r ? bank1_rd_r : bank0_rd_r;

  // Merge one element a cycle: drop the displaced sample, insert the new one in order
  assign exhausted = (i_r == n_r);
  assign need_rm = (old_r != '0) && !rm_r;
  assign need_ins = (lat_r != '0) && !ins_r;

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    rm_nxt = rm_r;
    ins_nxt = ins_r;
    wr_en = 1'b0;
    wr_data = rd_data;
    if (cmd.load) begin
      i_nxt = '0;
      j_nxt = '0;
      rm_nxt = 1'b0;
      ins_nxt = 1'b0;
    end else if (cmd.merge) begin
      priority if (!exhausted && need_rm && (rd_data == old_r)) begin
        rm_nxt = 1'b1;
        i_nxt = i_r + 1'b1;
      end else if (need_ins && (exhausted || (lat_r <= rd_data))) begin
        wr_en = 1'b1;
        wr_data = lat_r;
        ins_nxt = 1'b1;
        j_nxt = j_r + 1'b1;
      end else if (!exhausted) begin
        wr_en = 1'b1;
        wr_data = rd_data;
        i_nxt = i_r + 1'b1;
        j_nxt = j_r + 1'b1;
      end else begin
        wr_en = 1'b0;
      end
    end
  end

  assign st.merge_done = exhausted && !need_ins;
  assign st.out_free = !out_valid_r || !out_stall;

  // Read address for the sorted banks
  assign idx50 = n_r >> 1;
  always_comb begin
    unique case (cmd.rsel)
      lwp_pkg::RSEL_SCAN: rd_addr = i_nxt[AW-1:0];
      lwp_pkg::RSEL_P50:  rd_addr = idx50[AW-1:0];
      lwp_pkg::RSEL_P95:  rd_addr = idx95_r[AW-1:0];
      lwp_pkg::RSEL_P99:  rd_addr = idx99_r[AW-1:0];
      default:            rd_addr = i_nxt[AW-1:0];
    endcase
  end

  // Sample ring: one write per word, registered read of the slot being displaced
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring_mem[ws_r] <= lat_r;
    end
    ring_rd_r <= ring_mem[ws_r];
  end

  // Sorted banks: read one, write the other
  always_ff @(posedge clk) begin
    if (wr_en && sel_r) begin
      bank0_mem[j_r[AW-1:0]] <= wr_data;
    end
    bank0_rd_r <= bank0_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && !sel_r) begin
      bank1_mem[j_r[AW-1:0]] <= wr_data;
    end
    bank1_rd_r <= bank1_mem[rd_addr];
  end

  // Percentile index math on the new count
  assign sum20 = XW'(n_r) + XW'(lwp_pkg::ADD20);
  assign sum100 = XW'(n_r) + XW'(lwp_pkg::ADD100);
  assign prod20 = PW'(sum20) * PW'(lwp_pkg::MUL20);
  assign prod100 = PW'(sum100) * PW'(lwp_pkg::MUL100);

  // Saturate the reported count
  assign n_ext = (CW + lwp_pkg::CNT_W)'(n_r);
  assign cnt_sat = (n_ext > (CW + lwp_pkg::CNT_W)'(lwp_pkg::COUNT_MAX)) ?
                   lwp_pkg::CNT_W'(lwp_pkg::COUNT_MAX) : n_ext[lwp_pkg::CNT_W-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= '0;
      full_r <= 1'b0;
      n_r <= '0;
      sel_r <= 1'b0;
      out_valid_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
      rm_r <= 1'b0;
      ins_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      rm_r <= rm_nxt;
      ins_r <= ins_nxt;
      if (cmd.load) begin
        if (ws_r == AW'(WINDOW_DEPTH - 1)) begin
          ws_r <= '0;
          full_r <= 1'b1;
        end else begin
          ws_r <= ws_r + 1'b1;
        end
      end
      if (cmd.fin) begin
        n_r <= j_r;
        sel_r <= ~sel_r;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat_r <= in_latency_us;
    end
    if (cmd.load) begin
      old_r <= full_r ? ring_rd_r : '0;
    end
    if (cmd.div) begin
      q20_r <= prod20[lwp_pkg::DIV_SHIFT +: CW];
      q100_r <= prod100[lwp_pkg::DIV_SHIFT +: CW];
    end
    if (cmd.idx) begin
      idx95_r <= n_r - q20_r;
      idx99_r <= n_r - q100_r;
    end
    if (cmd.cap_med) begin
      med_r <= rd_data;
    end
    if (cmd.cap_p95) begin
      p95_r <= rd_data;
    end
    if (cmd.push) begin
      if (n_r == '0) begin
        med_out_r <= '0;
        p95_out_r <= '0;
        p99_out_r <= '0;
      end else begin
        med_out_r <= med_r;
        p95_out_r <= p95_r;
        p99_out_r <= rd_data;
      end
      cnt_out_r <= cnt_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_median_us = med_out_r;
  assign out_pct95_us = p95_out_r;
  assign out_pct99_us = p99_out_r;
  assign out_nonzero_count = cnt_out_r;

endmodule

FILE: tb/tb_latency_window_percentiles_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for latency_window_percentiles_unit.
// Keeps a sorted copy of the sample window to predict each percentile word.
// Depends on lwp_pkg and the unit's RTL.
module tb_latency_window_percentiles_unit;

  localparam int LAT_W = lwp_pkg::LAT_W;
  localparam int CNT_W = lwp_pkg::CNT_W;
  localparam int COUNT_MAX = lwp_pkg::COUNT_MAX;

  localparam int WINDOW_DEPTH = 1024;
  localparam int DIR_ROWS = 20;
  localparam int RAND_PER_PHASE = 345;
  localparam int NUM_PHASES = 4;
  localparam int TAIL_CYCLES = WINDOW_DEPTH + 64;
  localparam int MAX_REPORTS = 10;
  // well above the worst-case run length
  localparam longint CYCLE_LIMIT = 64'd10_000_000;

  typedef struct packed {
    logic [LAT_W-1:0] median;
    logic [LAT_W-1:0] p95;
    logic [LAT_W-1:0] p99;
    logic [CNT_W-1:0] count;
  } pctl_t;

  typedef struct packed {
    logic [LAT_W-1:0] lat;
    bit               typed;
    pctl_t            res;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [LAT_W-1:0] in_latency_us = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [LAT_W-1:0] out_median_us;
  logic [LAT_W-1:0] out_pct95_us;
  logic [LAT_W-1:0] out_pct99_us;
  logic [CNT_W-1:0] out_nonzero_count;

  // predictor state: the ring as written and its nonzero samples in order
  logic [LAT_W-1:0] ring_lat [WINDOW_DEPTH];
  logic [LAT_W-1:0] sorted_lat [WINDOW_DEPTH];
  int               ring_slot;
  int               held_cnt;

  pctl_t  pending_pctl_q [$];
  int     err_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  longint cycle_count = 0;

  latency_window_percentiles_unit #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_latency_us    (in_latency_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_us    (out_median_us),
    .out_pct95_us     (out_pct95_us),
    .out_pct99_us     (out_pct99_us),
    .out_nonzero_count(out_nonzero_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Write one sample into the window and compute the percentile word it yields
  task automatic window_percentiles(input logic [LAT_W-1:0] lat, output pctl_t res);
    logic [LAT_W-1:0] old_lat;
    int               pos;
    old_lat = ring_lat[ring_slot];
    ring_lat[ring_slot] = lat;
    ring_slot = (ring_slot == WINDOW_DEPTH - 1) ? 0 : ring_slot + 1;
    // drop the displaced sample from the sorted copy
    if (old_lat != '0) begin
      pos = 0;
      while (sorted_lat[pos] != old_lat) pos++;
      for (int k = pos; k < held_cnt - 1; k++) sorted_lat[k] = sorted_lat[k + 1];
      held_cnt--;
    end
    // insert the new sample in place; zero is never counted
    if (lat != '0) begin
      pos = held_cnt;
      while (pos > 0 && sorted_lat[pos - 1] > lat) begin
        sorted_lat[pos] = sorted_lat[pos - 1];
        pos--;
      end
      sorted_lat[pos] = lat;
      held_cnt++;
    end
    if (held_cnt == 0) begin
      res = '0;
    end else begin
      res.median = sorted_lat[held_cnt / 2];
      res.p95    = sorted_lat[(held_cnt * 95) / 100];
      res.p99    = sorted_lat[(held_cnt * 99) / 100];
      res.count  = (held_cnt > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(held_cnt);
    end
  endtask

  function automatic dir_row_t row(input logic [LAT_W-1:0] lat, input bit typed,
                                   input logic [LAT_W-1:0] m, input logic [LAT_W-1:0] p95,
                                   input logic [LAT_W-1:0] p99, input logic [CNT_W-1:0] cnt);
    dir_row_t r;
    r.lat   = lat;
    r.typed = typed;
    r.res   = '{median: m, p95: p95, p99: p99, count: cnt};
    return r;
  endfunction

  // Mix of zeros, full-range values, small duplicates, near-max values, single bits and values up to 1000
  function automatic logic [LAT_W-1:0] rand_latency();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return '0;
    else if (sel < 45) return LAT_W'($urandom());
    else if (sel < 65) return LAT_W'($urandom_range(16, 1));
    else if (sel < 75) return {LAT_W{1'b1}} - LAT_W'($urandom_range(15));
    else if (sel < 85) return LAT_W'(1) << $urandom_range(LAT_W - 1);
    else return LAT_W'($urandom_range(1000, 1));
  endfunction

  // Offer one word, wait for accept, then queue its expected result
  task automatic send_word(input logic [LAT_W-1:0] lat, input bit use_typed,
                           input pctl_t typed_res);
    pctl_t pred;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_latency_us <= lat;
    do @(posedge clk); while (in_stall);
    window_percentiles(lat, pred);
    pending_pctl_q = {pending_pctl_q, (use_typed ? typed_res : pred)};
  endtask

  // Hold the sender until every queued result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pctl_q.size() != 0) @(posedge clk);
  endtask

  // Randomize receiver backpressure
  always @(posedge clk) begin
    if (rst_n && stall_pct != 0) begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    pctl_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pctl_q.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("ERROR: result with nothing expected: med=%h p95=%h p99=%h n=%0d",
                   out_median_us, out_pct95_us, out_pct99_us, out_nonzero_count);
        err_count++;
      end else begin
        want = pending_pctl_q.pop_front();
        if (out_median_us !== want.median || out_pct95_us !== want.p95 ||
            out_pct99_us !== want.p99 || out_nonzero_count !== want.count) begin
          if (err_count < MAX_REPORTS)
            $display("ERROR: exp med=%h p95=%h p99=%h n=%0d, got med=%h p95=%h p99=%h n=%0d",
                     want.median, want.p95, want.p99, want.count, out_median_us,
                     out_pct95_us, out_pct99_us, out_nonzero_count);
          err_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_table [DIR_ROWS];
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      ring_lat[i]   = '0;
      sorted_lat[i] = '0;
    end
    ring_slot = 0;
    held_cnt  = 0;

    // after reset, the empty window, the max value and its pairing are typed in
    dir_table[0]  = row(24'h000000, 1'b1, 24'h000000, 24'h000000, 24'h000000, 11'd0);
    dir_table[1]  = row(24'hFFFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 11'd1);
    dir_table[2]  = row(24'h000000, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 11'd1);
    dir_table[3]  = row(24'h000001, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 11'd2);
    dir_table[4]  = row(24'h800000, 1'b0, '0, '0, '0, '0);
    dir_table[5]  = row(24'h7FFFFF, 1'b0, '0, '0, '0, '0);
    dir_table[6]  = row(24'h555555, 1'b0, '0, '0, '0, '0);
    dir_table[7]  = row(24'hAAAAAA, 1'b0, '0, '0, '0, '0);
    dir_table[8]  = row(24'h000005, 1'b0, '0, '0, '0, '0);
    dir_table[9]  = row(24'h000005, 1'b0, '0, '0, '0, '0);
    dir_table[10] = row(24'h000005, 1'b0, '0, '0, '0, '0);
    dir_table[11] = row(24'h000001, 1'b0, '0, '0, '0, '0);
    dir_table[12] = row(24'hFFFFFE, 1'b0, '0, '0, '0, '0);
    dir_table[13] = row(24'h000000, 1'b0, '0, '0, '0, '0);
    dir_table[14] = row(24'h0F0F0F, 1'b0, '0, '0, '0, '0);
    dir_table[15] = row(24'hF0F0F0, 1'b0, '0, '0, '0, '0);
    dir_table[16] = row(24'h000100, 1'b0, '0, '0, '0, '0);
    dir_table[17] = row(24'h010000, 1'b0, '0, '0, '0, '0);
    dir_table[18] = row(24'hFFFFFF, 1'b0, '0, '0, '0, '0);
    dir_table[19] = row(24'h000000, 1'b0, '0, '0, '0, '0);

    // hold reset, then release once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words with no idling
    for (int i = 0; i < DIR_ROWS; i++) send_word(dir_table[i].lat, dir_table[i].typed,
                                                 dir_table[i].res);
    drain_results();

    // random words over the idling and backpressure phases; drain between phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) send_word(rand_latency(), 1'b0, '0);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_pctl_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
